### rtl/nsso_pkg.sv
// shared constants, note frequency table and table-building functions for the tone source
package nsso_pkg;

    // default build parameters
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_INDEX_BITS_DEF = 10;
    localparam int SAMPLE_RATE_HZ_DEF  = 44100;
    localparam int NOTE_COUNT_DEF      = 128;

    // field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 16;
    localparam int NOTE_W   = 7;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = AMP_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_BUTTON = 2'd1;
    localparam logic [OP_W-1:0] OP_ENC    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_HIGH = 2'd2;

    // reset values
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST = 15'd10000;
    localparam logic [NOTE_W-1:0] WRAP_LOW_RST  = 7'd12;
    localparam logic [NOTE_W-1:0] WRAP_HIGH_RST = 7'd96;
    localparam logic [NOTE_W-1:0] NOTE_RST      = 7'd60;

    // 2*pi in unsigned q4.28
    localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

    // note frequencies in milli-hertz
    localparam logic [23:0] NOTE_MHZ [128] = '{
        24'd8176, 24'd8662, 24'd9177, 24'd9723, 24'd10301, 24'd10913, 24'd11562, 24'd12250,
        24'd12978, 24'd13750, 24'd14568, 24'd15434, 24'd16352, 24'd17324, 24'd18354,
        24'd19445, 24'd20602, 24'd21827, 24'd23125, 24'd24500, 24'd25957, 24'd27500,
        24'd29135, 24'd30868, 24'd32703, 24'd34648, 24'd36708, 24'd38891, 24'd41203,
        24'd43654, 24'd46249, 24'd48999, 24'd51913, 24'd55000, 24'd58270, 24'd61735,
        24'd65406, 24'd69296, 24'd73416, 24'd77782, 24'd82407, 24'd87307, 24'd92499,
        24'd97999, 24'd103826, 24'd110000, 24'd116541, 24'd123471, 24'd130813, 24'd138591,
        24'd146832, 24'd155563, 24'd164814, 24'd174614, 24'd184997, 24'd195998, 24'd207652,
        24'd220000, 24'd233082, 24'd246942, 24'd261626, 24'd277183, 24'd293665, 24'd311127,
        24'd329628, 24'd349228, 24'd369994, 24'd391995, 24'd415305, 24'd440000, 24'd466164,
        24'd493883, 24'd523251, 24'd554365, 24'd587330, 24'd622254, 24'd659255, 24'd698456,
        24'd739989, 24'd783991, 24'd830609, 24'd880000, 24'd932328, 24'd987767, 24'd1046502,
        24'd1108731, 24'd1174659, 24'd1244508, 24'd1318510, 24'd1396913, 24'd1479978,
        24'd1567982, 24'd1661219, 24'd1760000, 24'd1864655, 24'd1975533, 24'd2093005,
        24'd2217461, 24'd2349318, 24'd2489016, 24'd2637020, 24'd2793826, 24'd2959955,
        24'd3135963, 24'd3322438, 24'd3520000, 24'd3729310, 24'd3951066, 24'd4186009,
        24'd4434922, 24'd4698636, 24'd4978032, 24'd5274041, 24'd5587652, 24'd5919911,
        24'd6271927, 24'd6644875, 24'd7040000, 24'd7458620, 24'd7902133, 24'd8372018,
        24'd8869844, 24'd9397273, 24'd9956063, 24'd10548080, 24'd11175300, 24'd11839820,
        24'd12543850
    };

    // first-quadrant sine in q15, taylor series in q4.28, built at elaboration
    function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int sib);
        logic [63:0] half;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      s;
        half = 64'd1 << (sib - 1);
        x    = (k * TWO_PI_Q28 + half) >> sib;
        x2   = (x * x) >> 28;
        t    = x;
        s    = longint'(x);
        t = ((t * x2) >> 28) / 64'd6;
        s = s - longint'(t);
        t = ((t * x2) >> 28) / 64'd20;
        s = s + longint'(t);
        t = ((t * x2) >> 28) / 64'd42;
        s = s - longint'(t);
        t = ((t * x2) >> 28) / 64'd72;
        s = s + longint'(t);
        t = ((t * x2) >> 28) / 64'd110;
        s = s - longint'(t);
        t = ((t * x2) >> 28) / 64'd156;
        s = s + longint'(t);
        t = ((t * x2) >> 28) / 64'd210;
        s = s - longint'(t);
        if (s < 0) begin
            s = 0;
        end
        s = (s + 4096) >>> 13;
        if (s > 32767) begin
            s = 32767;
        end
        return 64'(s);
    endfunction

    // phase increment for a note, rounded half up, by restoring division
    function automatic logic [63:0] tuning_word(input int note, input int pb, input int rate,
                                                input int nc);
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        q   = 64'd0;
        den = 64'(rate) * 64'd1000;
        if (note >= nc || note >= 128) begin
            return 64'd0;
        end
        r = 64'(NOTE_MHZ[note]);
        for (int i = 0; i < 4; i++) begin
            if (r >= den) begin
                r = r - den;
                q = q + 64'd1;
            end
        end
        for (int i = 0; i < pb; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q + 64'd1;
            end
        end
        if ((r << 1) >= den) begin
            q = q + 64'd1;
        end
        if (pb < 64) begin
            q = q & ((64'd1 << pb) - 64'd1);
        end
        return q;
    endfunction

endpackage

### rtl/note_selectable_sine_oscillator_core.sv
// event-driven direct digital synthesis tone source with note selection
// each transaction passes through an input register and a result register
// throughput: one transaction per cycle while the result is taken; a tick does table lookup,
// one 15x15 multiply and the phase add in the single stage between the two registers
// reset (synchronous, active low): silent, phase 0, note 60, amplitude 10000, wrap 12..96
// no clearing pass; the block takes transactions as soon as reset is released
module note_selectable_sine_oscillator_core #(
    parameter int PHASE_BITS      = nsso_pkg::PHASE_BITS_DEF,
    parameter int SINE_INDEX_BITS = nsso_pkg::SINE_INDEX_BITS_DEF,
    parameter int SAMPLE_RATE_HZ  = nsso_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int NOTE_COUNT      = nsso_pkg::NOTE_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nsso_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nsso_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [nsso_pkg::OP_W-1:0]          i_op,
    input  logic signed [nsso_pkg::POS_W-1:0]  i_position,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [nsso_pkg::SAMPLE_W-1:0] o_sample,
    output logic                               o_sample_valid,
    output logic                               o_playing,
    output logic [nsso_pkg::NOTE_W-1:0]        o_note_index,
    output logic                               o_encoder_reload
);
    localparam int AW = nsso_pkg::AMP_W;
    localparam int NW = nsso_pkg::NOTE_W;

    // configuration
    logic [AW-1:0] r_amplitude;
    logic [NW-1:0] r_wrap_low;
    logic [NW-1:0] r_wrap_high;

    // input register
    logic                               r_in_vld;
    logic [nsso_pkg::OP_W-1:0]          r_op;
    logic signed [nsso_pkg::POS_W-1:0]  r_pos;

    // state
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [NW-1:0]         r_note;
    logic [NW-1:0]         n_note;
    logic                  r_play;
    logic                  n_play;

    // result register
    logic                                r_out_vld;
    logic signed [nsso_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [nsso_pkg::SAMPLE_W-1:0] n_sample;
    logic                                r_sample_valid;
    logic                                n_sample_valid;
    logic                                r_reload;
    logic                                n_reload;

    logic                  s_adv;
    logic [PHASE_BITS-1:0] s_tune;
    logic [AW-1:0]         s_mag;
    logic                  s_neg;
    logic [2*AW-1:0]       s_prod;
    logic [AW-1:0]         s_scaled;
    logic signed [nsso_pkg::POS_W-1:0] s_note_s;
    logic signed [nsso_pkg::POS_W-1:0] s_low_s;
    logic signed [nsso_pkg::POS_W-1:0] s_high_s;

    assign s_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || s_adv;

    nsso_rom #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_INDEX_BITS (SINE_INDEX_BITS),
        .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ),
        .NOTE_COUNT      (NOTE_COUNT)
    ) u_rom (
        .i_note     (r_note),
        .i_sine_idx (r_phase[PHASE_BITS-1 -: SINE_INDEX_BITS]),
        .o_tune     (s_tune),
        .o_sine_mag (s_mag),
        .o_sine_neg (s_neg)
    );

    assign s_prod   = (2*AW)'(r_amplitude) * (2*AW)'(s_mag);
    assign s_scaled = s_prod[2*AW-1:AW];
    assign s_note_s = $signed({{(nsso_pkg::POS_W-NW){1'b0}}, r_note});
    assign s_low_s  = $signed({{(nsso_pkg::POS_W-NW){1'b0}}, r_wrap_low});
    assign s_high_s = $signed({{(nsso_pkg::POS_W-NW){1'b0}}, r_wrap_high});

    always_comb begin
        n_phase        = r_phase;
        n_note         = r_note;
        n_play         = r_play;
        n_sample       = '0;
        n_sample_valid = 1'b0;
        n_reload       = 1'b0;
        case (r_op)
            nsso_pkg::OP_TICK: begin
                if (r_play) begin
                    n_sample       = s_neg ? -$signed({1'b0, s_scaled}) : $signed({1'b0, s_scaled});
                    n_sample_valid = 1'b1;
                    n_phase        = r_phase + s_tune;
                end
            end
            nsso_pkg::OP_BUTTON: begin
                n_play = !r_play;
                if (!r_play) begin
                    n_phase = '0;
                end
            end
            nsso_pkg::OP_ENC: begin
                if (r_pos != s_note_s) begin
                    if (r_pos < s_low_s) begin
                        n_note   = r_wrap_high;
                        n_reload = 1'b1;
                    end else if (r_pos > s_high_s) begin
                        n_note   = r_wrap_low;
                        n_reload = 1'b1;
                    end else begin
                        n_note = r_pos[NW-1:0];
                    end
                    if (r_play) begin
                        n_phase = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= nsso_pkg::AMPLITUDE_RST;
            r_wrap_low  <= nsso_pkg::WRAP_LOW_RST;
            r_wrap_high <= nsso_pkg::WRAP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nsso_pkg::REG_AMPLITUDE: r_amplitude <= i_cfg_data;
                nsso_pkg::REG_WRAP_LOW:  r_wrap_low  <= i_cfg_data[NW-1:0];
                nsso_pkg::REG_WRAP_HIGH: r_wrap_high <= i_cfg_data[NW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op  <= i_op;
            r_pos <= i_position;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_note    <= nsso_pkg::NOTE_RST;
            r_play    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_adv) begin
                r_phase   <= n_phase;
                r_note    <= n_note;
                r_play    <= n_play;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_sample       <= n_sample;
            r_sample_valid <= n_sample_valid;
            r_reload       <= n_reload;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_sample         = r_sample;
    assign o_sample_valid   = r_sample_valid;
    assign o_playing        = r_play;
    assign o_note_index     = r_note;
    assign o_encoder_reload = r_reload;

    // a produced sample always comes with the play flag set
    a_valid_sample_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sample_valid |-> o_playing)
        else $error("sample flagged valid while silent");

    // silent results carry a zero sample
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sample_valid |-> o_sample == '0)
        else $error("nonzero sample without sample_valid");

    // starting play always restarts the phase
    a_start_clears_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && r_op == nsso_pkg::OP_BUTTON && !r_play |=> r_phase == '0 && r_play)
        else $error("phase not cleared on play start");

    // a tick while silent leaves the phase alone
    a_silent_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && r_op == nsso_pkg::OP_TICK && !r_play |=> $stable(r_phase))
        else $error("phase moved on a silent tick");

    // reload only follows an encoder transaction
    a_reload_from_encoder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && r_op != nsso_pkg::OP_ENC |=> !o_encoder_reload)
        else $error("encoder reload without encoder transaction");

endmodule

### rtl/nsso_rom.sv
// constant lookup tables: per-note phase increment and quarter-wave folded sine magnitude
module nsso_rom #(
    parameter int PHASE_BITS      = nsso_pkg::PHASE_BITS_DEF,
    parameter int SINE_INDEX_BITS = nsso_pkg::SINE_INDEX_BITS_DEF,
    parameter int SAMPLE_RATE_HZ  = nsso_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int NOTE_COUNT      = nsso_pkg::NOTE_COUNT_DEF
) (
    input  logic [nsso_pkg::NOTE_W-1:0] i_note,
    input  logic [SINE_INDEX_BITS-1:0]  i_sine_idx,
    output logic [PHASE_BITS-1:0]       o_tune,
    output logic [nsso_pkg::AMP_W-1:0]  o_sine_mag,
    output logic                        o_sine_neg
);
    localparam int QTR_BITS = SINE_INDEX_BITS - 2;
    localparam int QTR      = 1 << QTR_BITS;
    localparam int NOTES    = 1 << nsso_pkg::NOTE_W;

    logic [PHASE_BITS-1:0]      w_tune  [NOTES];
    logic [nsso_pkg::AMP_W-1:0] w_qsine [QTR+1];
    logic [QTR_BITS-1:0]        s_rem;
    logic [QTR_BITS:0]          s_addr;

    for (genvar g = 0; g < NOTES; g++) begin : g_tune
        assign w_tune[g] = PHASE_BITS'(nsso_pkg::tuning_word(g, PHASE_BITS, SAMPLE_RATE_HZ,
                                                             NOTE_COUNT));
    end

    for (genvar g = 0; g <= QTR; g++) begin : g_sine
        assign w_qsine[g] = nsso_pkg::AMP_W'(nsso_pkg::quarter_sine(64'(g), SINE_INDEX_BITS));
    end

    // odd quadrants read the table backwards
    assign s_rem  = i_sine_idx[QTR_BITS-1:0];
    assign s_addr = i_sine_idx[QTR_BITS] ? ((QTR_BITS+1)'(QTR) - {1'b0, s_rem})
                                         : {1'b0, s_rem};

    assign o_tune     = w_tune[i_note];
    assign o_sine_mag = w_qsine[s_addr];
    assign o_sine_neg = i_sine_idx[SINE_INDEX_BITS-1];

endmodule

### tb/note_selectable_sine_oscillator_core_tb.sv
// self-checking testbench for the note-selectable sine tone source core
module note_selectable_sine_oscillator_core_tb;

    localparam int PH_BITS     = nsso_pkg::PHASE_BITS_DEF;
    localparam int SINE_BITS   = nsso_pkg::SINE_INDEX_BITS_DEF;
    localparam int STALL_LIMIT = 500;
    localparam logic [nsso_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [nsso_pkg::SAMPLE_W-1:0] sample;
        logic                                 sample_valid;
        logic                                 playing;
        logic [nsso_pkg::NOTE_W-1:0]          note_index;
        logic                                 encoder_reload;
    } t_tone_status;

    // predicts each status result and checks the ones coming out of the core
    class t_tone_scoreboard;
        int                          sine_lut [1 << SINE_BITS];
        logic [PH_BITS-1:0]          step_rom [128];
        logic [PH_BITS-1:0]          phase;
        logic [nsso_pkg::NOTE_W-1:0] note;
        bit                          play_on;
        logic [nsso_pkg::AMP_W-1:0]  amp;
        logic [nsso_pkg::NOTE_W-1:0] wrap_lo;
        logic [nsso_pkg::NOTE_W-1:0] wrap_hi;
        t_tone_status                status_q [$];
        int n_errors, n_checked, n_samples, n_items;

        function new();
            logic [63:0] f;
            logic [63:0] den;
            int q;
            int r;
            int v;
            den = 64'(nsso_pkg::SAMPLE_RATE_HZ_DEF) * 64'd1000;
            for (int n = 0; n < 128; n++) begin
                f = 64'(nsso_pkg::NOTE_MHZ[n]);
                // round half up of f * 2^PH_BITS / den
                step_rom[n] = PH_BITS'(((f << (PH_BITS + 1)) + den) / (den << 1));
            end
            for (int i = 0; i < (1 << SINE_BITS); i++) begin
                q = i >> (SINE_BITS - 2);
                r = i & ((1 << (SINE_BITS - 2)) - 1);
                v = (q % 2 == 1) ? quarter_wave((1 << (SINE_BITS - 2)) - r) : quarter_wave(r);
                sine_lut[i] = (q >= 2) ? -v : v;
            end
            amp     = nsso_pkg::AMPLITUDE_RST;
            wrap_lo = nsso_pkg::WRAP_LOW_RST;
            wrap_hi = nsso_pkg::WRAP_HIGH_RST;
            note    = nsso_pkg::NOTE_RST;
            phase   = '0;
            play_on = 1'b0;
        endfunction

        // first quadrant in q15 from a truncated taylor series in q4.28
        function int quarter_wave(int unsigned k);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            longint      acc;
            int          n;
            x    = (64'(k) * nsso_pkg::TWO_PI_Q28 + (64'd1 << (SINE_BITS - 1))) >> SINE_BITS;
            x2   = (x * x) >> 28;
            term = x;
            acc  = longint'(x);
            for (n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 28) / 64'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc + 4096) >>> 13;
            if (acc > 32767) begin
                acc = 32767;
            end
            return int'(acc);
        endfunction

        function void write_reg(logic [nsso_pkg::CFG_IDX_W-1:0] idx,
                                logic [nsso_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                nsso_pkg::REG_AMPLITUDE: amp     = data[nsso_pkg::AMP_W-1:0];
                nsso_pkg::REG_WRAP_LOW:  wrap_lo = data[nsso_pkg::NOTE_W-1:0];
                nsso_pkg::REG_WRAP_HIGH: wrap_hi = data[nsso_pkg::NOTE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic [nsso_pkg::OP_W-1:0] op,
                                 logic signed [nsso_pkg::POS_W-1:0] pos);
            t_tone_status e;
            int sv;
            int unsigned mag;
            int unsigned prod;
            int p;
            e = '0;
            n_items++;
            case (op)
                nsso_pkg::OP_TICK: begin
                    if (play_on) begin
                        sv   = sine_lut[phase[PH_BITS-1 -: SINE_BITS]];
                        mag  = (sv < 0) ? -sv : sv;
                        prod = (int'(amp) * mag) >> 15;
                        e.sample       = (sv < 0) ? -nsso_pkg::SAMPLE_W'(prod)
                                                  : nsso_pkg::SAMPLE_W'(prod);
                        e.sample_valid = 1'b1;
                        phase = phase + step_rom[note];
                        n_samples++;
                    end
                end
                nsso_pkg::OP_BUTTON: begin
                    play_on = !play_on;
                    if (play_on) begin
                        phase = '0;
                    end
                end
                nsso_pkg::OP_ENC: begin
                    p = pos;
                    if (p != int'(note)) begin
                        // low bound is checked first, even with the bounds inverted
                        if (p < int'(wrap_lo)) begin
                            note = wrap_hi;
                            e.encoder_reload = 1'b1;
                        end else if (p > int'(wrap_hi)) begin
                            note = wrap_lo;
                            e.encoder_reload = 1'b1;
                        end else begin
                            note = p[nsso_pkg::NOTE_W-1:0];
                        end
                        if (play_on) begin
                            phase = '0;
                        end
                    end
                end
                default: ;
            endcase
            e.playing    = play_on;
            e.note_index = note;
            status_q.push_back(e);
        endfunction

        task report(string what, int got_v, int exp_v);
            n_errors++;
            $display("mismatch %0d at result %0d: %s got %0d expected %0d",
                     n_errors, n_checked, what, got_v, exp_v);
        endtask

        task check_result(t_tone_status got);
            t_tone_status e;
            n_checked++;
            if (status_q.size() == 0) begin
                report("result with no transaction outstanding", got.note_index, -1);
                return;
            end
            e = status_q.pop_front();
            if (got.sample !== e.sample)
                report("sample", int'(got.sample), int'(e.sample));
            if (got.sample_valid !== e.sample_valid)
                report("sample_valid", got.sample_valid, e.sample_valid);
            if (got.playing !== e.playing)
                report("playing", got.playing, e.playing);
            if (got.note_index !== e.note_index)
                report("note_index", got.note_index, e.note_index);
            if (got.encoder_reload !== e.encoder_reload)
                report("encoder_reload", got.encoder_reload, e.encoder_reload);
        endtask
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [nsso_pkg::CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [nsso_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                 i_valid = 1'b0;
    logic                                 o_ready;
    logic [nsso_pkg::OP_W-1:0]            i_op = '0;
    logic signed [nsso_pkg::POS_W-1:0]    i_position = '0;
    logic                                 o_valid;
    logic                                 i_ready = 1'b0;
    logic signed [nsso_pkg::SAMPLE_W-1:0] o_sample;
    logic                                 o_sample_valid;
    logic                                 o_playing;
    logic [nsso_pkg::NOTE_W-1:0]          o_note_index;
    logic                                 o_encoder_reload;

    t_tone_scoreboard sb;
    int send_idle_pct = 10;
    int recv_idle_pct = 53;
    int stall_cycles = 0;
    int n_settings = 1;

    note_selectable_sine_oscillator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample        (o_sample),
        .o_sample_valid  (o_sample_valid),
        .o_playing       (o_playing),
        .o_note_index    (o_note_index),
        .o_encoder_reload(o_encoder_reload)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result({o_sample, o_sample_valid, o_playing, o_note_index,
                             o_encoder_reload});
        end
    end

    // ends the run when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input logic [nsso_pkg::OP_W-1:0] op,
                             input logic signed [nsso_pkg::POS_W-1:0] pos);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(op, pos);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [nsso_pkg::CFG_IDX_W-1:0] idx,
                               input logic [nsso_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic [nsso_pkg::AMP_W-1:0] amp_v,
                                 input logic [nsso_pkg::NOTE_W-1:0] lo_v,
                                 input logic [nsso_pkg::NOTE_W-1:0] hi_v);
        hold_until_drained();
        program_reg(nsso_pkg::REG_AMPLITUDE, nsso_pkg::CFG_DATA_W'(amp_v));
        program_reg(nsso_pkg::REG_WRAP_LOW, nsso_pkg::CFG_DATA_W'(lo_v));
        program_reg(nsso_pkg::REG_WRAP_HIGH, nsso_pkg::CFG_DATA_W'(hi_v));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int count);
        int k;
        int r;
        int btn_pct;
        int sel;
        logic [nsso_pkg::OP_W-1:0]         op;
        logic signed [nsso_pkg::POS_W-1:0] pos;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) begin
                hold_until_drained();
            end
            // start playing quickly when silent, stop only now and then
            btn_pct = sb.play_on ? 3 : 30;
            r   = $urandom_range(0, 99);
            pos = nsso_pkg::POS_W'($urandom());
            if (r < btn_pct) begin
                op = nsso_pkg::OP_BUTTON;
            end else if (r < btn_pct + 5) begin
                op = OP_UNUSED;
            end else if (r < btn_pct + 30) begin
                op  = nsso_pkg::OP_ENC;
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    pos = nsso_pkg::POS_W'($urandom_range(0, 127));
                else if (sel < 55)
                    pos = nsso_pkg::POS_W'(sb.note);
                else if (sel < 65)
                    pos = nsso_pkg::POS_W'(int'(sb.wrap_lo) - int'($urandom_range(0, 2)));
                else if (sel < 75)
                    pos = nsso_pkg::POS_W'(int'(sb.wrap_hi) + int'($urandom_range(0, 2)));
            end else begin
                op = nsso_pkg::OP_TICK;
            end
            send_item(op, pos);
        end
    endtask

    initial begin
        int ph;
        logic [nsso_pkg::AMP_W-1:0]  amp_v;
        logic [nsso_pkg::NOTE_W-1:0] lo_v;
        logic [nsso_pkg::NOTE_W-1:0] hi_v;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, silent tick, unused op, encoder edge cases
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(OP_UNUSED, -16'sd1);
        send_item(nsso_pkg::OP_ENC, 16'sd60);
        send_item(nsso_pkg::OP_ENC, -16'sd32768);
        send_item(nsso_pkg::OP_ENC, 16'sd32767);
        send_item(nsso_pkg::OP_ENC, 16'sd69);
        send_item(nsso_pkg::OP_BUTTON, 16'sd0);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(nsso_pkg::OP_ENC, 16'sd69);
        send_item(nsso_pkg::OP_ENC, 16'sd0);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        // wraps back onto the same note, still clears the phase
        send_item(nsso_pkg::OP_ENC, -16'sd5);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(OP_UNUSED, 16'sd100);
        send_item(nsso_pkg::OP_BUTTON, 16'sd0);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(nsso_pkg::OP_BUTTON, 16'sd0);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        apply_setting(15'd32767, 7'd0, 7'd127);
        send_item(nsso_pkg::OP_ENC, 16'sd127);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        // inverted bounds with zero amplitude
        apply_setting(15'd0, 7'd100, 7'd20);
        send_item(nsso_pkg::OP_ENC, 16'sd50);
        send_item(nsso_pkg::OP_TICK, 16'sd0);
        send_item(nsso_pkg::OP_ENC, 16'sd110);

        for (ph = 0; ph < 6; ph++) begin
            amp_v = nsso_pkg::AMP_W'($urandom());
            lo_v  = nsso_pkg::NOTE_W'($urandom());
            hi_v  = nsso_pkg::NOTE_W'($urandom());
            case (ph)
                0: begin
                    lo_v = 7'd0;
                    hi_v = 7'd127;
                end
                1: begin
                    lo_v = nsso_pkg::NOTE_W'($urandom_range(0, 60));
                    hi_v = nsso_pkg::NOTE_W'($urandom_range(61, 127));
                end
                2: amp_v = 15'd32767;
                3: begin
                    lo_v = nsso_pkg::NOTE_W'($urandom_range(64, 127));
                    hi_v = nsso_pkg::NOTE_W'($urandom_range(0, 63));
                end
                4: hi_v = lo_v;
                default: ;
            endcase
            send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 53 : 0;
            recv_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 10 : 0;
            apply_setting(amp_v, lo_v, hi_v);
            run_random(305);
        end

        hold_until_drained();
        repeat (4) @(posedge i_clk);
        $display("covered %0d transactions, %0d of them tone samples, over %0d register settings",
                 sb.n_items, sb.n_samples, n_settings);
        $display("checked %0d results, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
